// ----- hdl/dbvrs_pkg.sv -----
// shared types and constants for the dual-bank versioned retain store
`default_nettype none

package dbvrs_pkg;

    // field widths
    localparam int OP_W     = 3;
    localparam int OFF_W    = 11;
    localparam int SPAN_W   = 12;
    localparam int DATA_W   = 8;
    localparam int VER_W    = 32;

    // bank geometry
    localparam int BANK_BYTES = 2048;
    localparam int MEM_DEPTH  = 2 * BANK_BYTES;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    // done word value after reset all
    localparam logic [VER_W-1:0] DONE_RESET = VER_W'(32'hFF);
    localparam logic [VER_W-1:0] OPEN_RESET = '0;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_BEGIN  = 3'd2,
        OP_RESET  = 3'd3,
        OP_COMMIT = 3'd4,
        OP_CHECK  = 3'd5
    } t_opcode;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ----- hdl/dbvrs_ram.sv -----
// generic single-port ram with registered read
`default_nettype none

module dbvrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/dbvrs_ctrl.sv -----
// controller state machine: capture, execute, respond
`default_nettype none

module dbvrs_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    output logic                    o_valid,
    output dbvrs_pkg::t_dp_cmd      o_cmd
);

    import dbvrs_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_busy       = 1'b1;
        o_valid      = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.exec   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_RESP;
            end
            ST_RESP: begin
                o_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/dbvrs_datapath.sv -----
// datapath: version words, bank selection, span check and byte memory
`default_nettype none

module dbvrs_datapath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire dbvrs_pkg::t_dp_cmd               i_cmd,
    input  wire logic [dbvrs_pkg::OP_W-1:0]       i_opcode,
    input  wire logic [dbvrs_pkg::OFF_W-1:0]      i_byte_offset,
    input  wire logic [dbvrs_pkg::SPAN_W-1:0]     i_span_end,
    input  wire logic [dbvrs_pkg::DATA_W-1:0]     i_wr_data,
    output logic      [dbvrs_pkg::DATA_W-1:0]     o_rd_data,
    output logic                                  o_any_valid,
    output logic                                  o_rejected,
    output logic                                  o_bank_used
);

    import dbvrs_pkg::*;

    // captured item
    t_opcode             r_op;
    logic [OFF_W-1:0]    r_off;
    logic [SPAN_W-1:0]   r_end;
    logic [DATA_W-1:0]   r_wdata;

    // version words
    logic [VER_W-1:0]    r_fo, r_fd, r_so, r_sd;
    logic [VER_W-1:0]    n_fo, n_fd, n_so, n_sd;

    // result registers
    logic                r_any_valid;
    logic                r_rej;
    logic                r_bank;
    logic                r_rd_ok;

    logic                f_valid, s_valid;
    logic                first_newer;
    logic                rd_bank;
    logic                sel_bank;
    logic                span_ok;
    logic                is_read, is_write;
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_addr;
    logic [DATA_W-1:0]   mem_q;

    // capture the item on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_opcode'(i_opcode);
            r_off   <= i_byte_offset;
            r_end   <= i_span_end;
            r_wdata <= i_wr_data;
        end
    end

    // bank status and selection
    always_comb begin
        f_valid     = (r_fo == r_fd);
        s_valid     = (r_so == r_sd);
        first_newer = (r_fo >= r_so);
        if (f_valid && s_valid) begin
            rd_bank = (r_sd > r_fd);
        end else begin
            rd_bank = s_valid;
        end
        span_ok  = (r_end <= SPAN_W'(BANK_BYTES))
                && ({1'b0, r_off} < SPAN_W'(BANK_BYTES));
        is_read  = (r_op == OP_READ);
        is_write = (r_op == OP_WRITE);
        sel_bank = is_read ? rd_bank : !first_newer;
        mem_addr = {sel_bank, r_off};
        mem_we   = i_cmd.exec && is_write && span_ok;
        mem_re   = i_cmd.exec && is_read && span_ok;
    end

    // version word updates
    always_comb begin
        n_fo = r_fo;
        n_fd = r_fd;
        n_so = r_so;
        n_sd = r_sd;
        unique case (r_op)
            OP_BEGIN: begin
                if (first_newer) begin
                    n_so = r_fo + VER_W'(1);
                end else begin
                    n_fo = r_so + VER_W'(1);
                end
            end
            OP_RESET: begin
                n_fo = OPEN_RESET;
                n_so = OPEN_RESET;
                n_fd = DONE_RESET;
                n_sd = DONE_RESET;
            end
            OP_COMMIT: begin
                if (first_newer) begin
                    n_fd = r_fo;
                end else begin
                    n_sd = r_so;
                end
            end
            default: begin
            end
        endcase
    end

    // version registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fo <= OPEN_RESET;
            r_so <= OPEN_RESET;
            r_fd <= DONE_RESET;
            r_sd <= DONE_RESET;
        end else if (i_cmd.exec) begin
            r_fo <= n_fo;
            r_so <= n_so;
            r_fd <= n_fd;
            r_sd <= n_sd;
        end
    end

    // result flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_any_valid <= (n_fo == n_fd) || (n_so == n_sd);
            r_rej       <= (is_read || is_write) && !span_ok;
            r_bank      <= (is_read || is_write) && sel_bank;
            r_rd_ok     <= is_read && span_ok;
        end
    end

    // byte memory for both banks
    dbvrs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (r_wdata),
        .o_rdata (mem_q)
    );

    assign o_rd_data   = r_rd_ok ? mem_q : '0;
    assign o_any_valid = r_any_valid;
    assign o_rejected  = r_rej;
    assign o_bank_used = r_bank;

endmodule

`default_nettype wire

// ----- hdl/dual_bank_versioned_retain_store_unit.sv -----
// top level of the dual-bank versioned retain store
//
// Each item is captured at the edge where start is high and busy is low,
// executed in the next cycle (version update, bank selection, span check and
// the byte memory access), and its result is shown in the cycle after that
// for exactly one cycle with o_valid high, when the registered read of the
// byte memory is available. busy stays high from the capture edge until the
// result cycle ends, so a new item is taken only after the previous result
// has been shown. The receiver cannot stall and must take each result in its
// o_valid cycle. The byte memory is not cleared at reset: reading a byte
// never written returns an undefined value.
`default_nettype none

module dual_bank_versioned_retain_store_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [dbvrs_pkg::OP_W-1:0]       i_opcode,
    input  wire logic [dbvrs_pkg::OFF_W-1:0]      i_byte_offset,
    input  wire logic [dbvrs_pkg::SPAN_W-1:0]     i_span_end,
    input  wire logic [dbvrs_pkg::DATA_W-1:0]     i_wr_data,
    output logic                                  o_valid,
    output logic      [dbvrs_pkg::DATA_W-1:0]     o_rd_data,
    output logic                                  o_any_valid,
    output logic                                  o_rejected,
    output logic                                  o_bank_used
);

    import dbvrs_pkg::*;

    t_dp_cmd dp_cmd;

    // sequencing
    dbvrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_cmd   (dp_cmd)
    );

    // versions, selection and storage
    dbvrs_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_opcode      (i_opcode),
        .i_byte_offset (i_byte_offset),
        .i_span_end    (i_span_end),
        .i_wr_data     (i_wr_data),
        .o_rd_data     (o_rd_data),
        .o_any_valid   (o_any_valid),
        .o_rejected    (o_rejected),
        .o_bank_used   (o_bank_used)
    );

endmodule

`default_nettype wire

// ----- hdl/dbvrs_checker.sv -----
// port-level checker for the retain store, bound to the top level
`default_nettype none

module dbvrs_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          o_valid,
    input wire logic [dbvrs_pkg::DATA_W-1:0]  o_rd_data,
    input wire logic                          o_rejected
);

    // an accepted item makes the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after item accept");

    // every accepted item gives its result strobe once its execute step has passed
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result strobe missing after accepted item");

    // the result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // a result only appears while an item is in flight
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe without busy");

    // a refused access reads as zero
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rejected) |-> (o_rd_data == '0))
        else $error("rejected access returned data");

endmodule

bind dual_bank_versioned_retain_store_unit dbvrs_checker u_dbvrs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_rd_data  (o_rd_data),
    .o_rejected (o_rejected)
);

`default_nettype wire
